### hw/rtl/vlpd_pkg.sv
package vlpd_pkg;

    // varint geometry
    localparam int MAX_VARINT_BYTES = 3;
    localparam int GROUP_W = 7;
    localparam int VAL_W = GROUP_W * MAX_VARINT_BYTES;
    localparam int LEN_W = 21;
    localparam int CMP_W = (VAL_W > LEN_W) ? VAL_W : LEN_W;
    localparam int HB_W = 2;
    localparam int SH_W = 5;

    // configuration port
    localparam int ADDR_W = 3;
    localparam int DATA_W = 32;
    localparam logic REG_COMPRESSED_MODE = 1'b0;
    localparam logic REG_MAX_PACKET_LENGTH = 1'b1;
    localparam logic [LEN_W-1:0] MAX_LEN_RESET = LEN_W'(32768);

    // result kinds
    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_ERROR = 1'b1;

    // protocol error codes
    localparam logic [1:0] ERR_TOO_LARGE = 2'd0;
    localparam logic [1:0] ERR_TOO_LONG = 2'd1;
    localparam logic [1:0] ERR_ZERO_LENGTH = 2'd2;
    localparam logic [1:0] ERR_COMPRESSED = 2'd3;

    // parser phase, one-hot
    typedef enum logic [2:0] {
        PH_PLEN = 3'b001,
        PH_DLEN = 3'b010,
        PH_DATA = 3'b100
    } phase_t;

    // one result beat
    typedef struct packed {
        logic       kind;
        logic [7:0] payload;
        logic       first;
        logic       last;
        logic [1:0] code;
    } result_t;

endpackage

### hw/rtl/varint_length_packet_deframer.sv
// path: a byte taken into the input register steps the parser, and its result
// beat is then registered in the result register, from which it leaves
// throughput: one byte per cycle; a byte, header bytes too, waits in the input
// register while a stalled beat holds the result register
// reset: rst_n (async, active low) returns the parser to the packet length
// varint, clears any latched error, and restores the register defaults
module varint_length_packet_deframer (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [vlpd_pkg::ADDR_W-1:0]    paddr,
    input  logic [vlpd_pkg::DATA_W-1:0]    pwdata,
    output logic [vlpd_pkg::DATA_W-1:0]    prdata,
    output logic                           pready,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [7:0]                     byte_in,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic                           result_kind,
    output logic [7:0]                     payload_byte,
    output logic                           first_of_packet,
    output logic                           last_of_packet,
    output logic [1:0]                     error_code
);

    logic                          cm_reg;
    logic [vlpd_pkg::LEN_W-1:0]    max_len_reg;
    logic                          cfg_wr;
    logic                          in_valid_reg;
    logic [7:0]                    byte_reg;
    logic                          out_free;
    logic                          step;
    logic                          accept;
    logic                          res_valid;
    vlpd_pkg::result_t             res;
    vlpd_pkg::result_t             out_data;

    // configuration registers
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cm_reg <= 1'b0;
            max_len_reg <= vlpd_pkg::MAX_LEN_RESET;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[2])
                vlpd_pkg::REG_COMPRESSED_MODE:   cm_reg <= pwdata[0];
                vlpd_pkg::REG_MAX_PACKET_LENGTH: max_len_reg <= pwdata[vlpd_pkg::LEN_W-1:0];
                default:                         cm_reg <= cm_reg;
            endcase
        end
    end

    // register readback
    always_comb
    begin
        unique case (paddr[2])
            vlpd_pkg::REG_COMPRESSED_MODE:   prdata = vlpd_pkg::DATA_W'(cm_reg);
            vlpd_pkg::REG_MAX_PACKET_LENGTH: prdata = vlpd_pkg::DATA_W'(max_len_reg);
            default:                         prdata = '0;
        endcase
    end

    // input register
    assign step = in_valid_reg && out_free;
    assign in_stall = in_valid_reg && !out_free;
    assign accept = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (step)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            byte_reg <= byte_in;
        end
    end

    // header parse and payload marking
    vlpd_parse u_parse (
        .clk             (clk),
        .rst_n           (rst_n),
        .step            (step),
        .byte_val        (byte_reg),
        .compressed_mode (cm_reg),
        .max_len         (max_len_reg),
        .res_valid       (res_valid),
        .res             (res)
    );

    // result register
    vlpd_out_reg u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (step && res_valid),
        .load_data (res),
        .stall     (out_stall),
        .free      (out_free),
        .valid     (out_valid),
        .data      (out_data)
    );

    assign result_kind = out_data.kind;
    assign payload_byte = out_data.payload;
    assign first_of_packet = out_data.first;
    assign last_of_packet = out_data.last;
    assign error_code = out_data.code;

endmodule

### hw/rtl/vlpd_parse.sv
module vlpd_parse (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          step,
    input  logic [7:0]                    byte_val,
    input  logic                          compressed_mode,
    input  logic [vlpd_pkg::LEN_W-1:0]    max_len,
    output logic                          res_valid,
    output vlpd_pkg::result_t             res
);

    vlpd_pkg::phase_t               phase_reg, phase_next;
    logic [vlpd_pkg::LEN_W-1:0]     pl_reg, pl_next;
    logic [vlpd_pkg::LEN_W-1:0]     dl_reg, dl_next;
    logic [vlpd_pkg::HB_W-1:0]      hb_reg, hb_next;
    logic [vlpd_pkg::LEN_W-1:0]     br_reg, br_next;
    logic                           start_reg, start_next;
    logic                           err_reg, err_next;

    logic [vlpd_pkg::HB_W-1:0]      k;
    logic [vlpd_pkg::SH_W-1:0]      sh;
    logic [vlpd_pkg::LEN_W-1:0]     old;
    logic [vlpd_pkg::VAL_W-1:0]     val;
    logic [vlpd_pkg::LEN_W-1:0]     val_len;
    logic                           more;
    logic                           too_large;
    logic                           too_long;
    logic                           fin;
    logic [vlpd_pkg::LEN_W-1:0]     fin_pl;
    logic [vlpd_pkg::LEN_W-1:0]     fin_dl;
    logic [vlpd_pkg::HB_W:0]        fin_bytes;

    // varint group merge
    always_comb
    begin
        k = hb_reg;
        if (int'(hb_reg) >= vlpd_pkg::MAX_VARINT_BYTES)
        begin
            k = vlpd_pkg::HB_W'(vlpd_pkg::MAX_VARINT_BYTES - 1);
        end
        sh = {k, 3'b000} - vlpd_pkg::SH_W'(k);
        old = (phase_reg == vlpd_pkg::PH_DLEN) ? dl_reg : pl_reg;
        if (k == '0)
        begin
            old = '0;
        end
        val = vlpd_pkg::VAL_W'(old) | (vlpd_pkg::VAL_W'(byte_val[6:0]) << sh);
        val_len = vlpd_pkg::LEN_W'(val);
        more = byte_val[7];
        too_large = vlpd_pkg::CMP_W'(val) > vlpd_pkg::CMP_W'(max_len);
        too_long = more && ((int'(k) + 1) >= vlpd_pkg::MAX_VARINT_BYTES);
    end

    // per-beat state update and result
    always_comb
    begin
        phase_next = phase_reg;
        pl_next = pl_reg;
        dl_next = dl_reg;
        hb_next = hb_reg;
        br_next = br_reg;
        start_next = start_reg;
        err_next = err_reg;
        res_valid = 1'b0;
        res = '0;
        fin = 1'b0;
        fin_pl = pl_reg;
        fin_dl = '0;
        fin_bytes = '0;

        if (!err_reg)
        begin
            if (phase_reg == vlpd_pkg::PH_DATA)
            begin
                // payload pass-through
                res_valid = 1'b1;
                res.kind = vlpd_pkg::KIND_PAYLOAD;
                res.payload = byte_val;
                res.first = start_reg;
                res.last = (br_reg <= vlpd_pkg::LEN_W'(1));
                start_next = 1'b0;
                if (br_reg <= vlpd_pkg::LEN_W'(1))
                begin
                    br_next = '0;
                    phase_next = vlpd_pkg::PH_PLEN;
                    hb_next = '0;
                end
                else
                begin
                    br_next = br_reg - vlpd_pkg::LEN_W'(1);
                end
            end
            else if (too_large)
            begin
                err_next = 1'b1;
                res_valid = 1'b1;
                res.kind = vlpd_pkg::KIND_ERROR;
                res.code = vlpd_pkg::ERR_TOO_LARGE;
            end
            else if (too_long)
            begin
                err_next = 1'b1;
                res_valid = 1'b1;
                res.kind = vlpd_pkg::KIND_ERROR;
                res.code = vlpd_pkg::ERR_TOO_LONG;
            end
            else if (phase_reg == vlpd_pkg::PH_DLEN)
            begin
                // data length varint
                dl_next = val_len;
                if (more)
                begin
                    hb_next = k + vlpd_pkg::HB_W'(1);
                end
                else
                begin
                    fin = 1'b1;
                    fin_dl = val_len;
                    fin_bytes = {1'b0, k} + (vlpd_pkg::HB_W + 1)'(1);
                end
            end
            else
            begin
                // packet length varint
                pl_next = val_len;
                if (more)
                begin
                    hb_next = k + vlpd_pkg::HB_W'(1);
                end
                else
                begin
                    hb_next = '0;
                    dl_next = '0;
                    if (compressed_mode)
                    begin
                        phase_next = vlpd_pkg::PH_DLEN;
                    end
                    else
                    begin
                        fin = 1'b1;
                        fin_pl = val_len;
                    end
                end
            end

            // header complete checks
            if (fin)
            begin
                if (fin_pl == '0)
                begin
                    err_next = 1'b1;
                    res_valid = 1'b1;
                    res.kind = vlpd_pkg::KIND_ERROR;
                    res.code = vlpd_pkg::ERR_ZERO_LENGTH;
                end
                else if (compressed_mode && (fin_dl != '0))
                begin
                    err_next = 1'b1;
                    res_valid = 1'b1;
                    res.kind = vlpd_pkg::KIND_ERROR;
                    res.code = vlpd_pkg::ERR_COMPRESSED;
                end
                else if (fin_pl <= vlpd_pkg::LEN_W'(fin_bytes))
                begin
                    err_next = 1'b1;
                    res_valid = 1'b1;
                    res.kind = vlpd_pkg::KIND_ERROR;
                    res.code = vlpd_pkg::ERR_ZERO_LENGTH;
                end
                else
                begin
                    br_next = fin_pl - vlpd_pkg::LEN_W'(fin_bytes);
                    start_next = 1'b1;
                    phase_next = vlpd_pkg::PH_DATA;
                    hb_next = '0;
                end
            end
        end
    end

    // parser state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= vlpd_pkg::PH_PLEN;
            pl_reg <= '0;
            dl_reg <= '0;
            hb_reg <= '0;
            br_reg <= '0;
            start_reg <= 1'b1;
            err_reg <= 1'b0;
        end
        else if (step)
        begin
            phase_reg <= phase_next;
            pl_reg <= pl_next;
            dl_reg <= dl_next;
            hb_reg <= hb_next;
            br_reg <= br_next;
            start_reg <= start_next;
            err_reg <= err_next;
        end
    end

endmodule

### hw/rtl/vlpd_out_reg.sv
module vlpd_out_reg (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  vlpd_pkg::result_t load_data,
    input  logic              stall,
    output logic              free,
    output logic              valid,
    output vlpd_pkg::result_t data
);

    logic              valid_reg;
    logic              valid_next;
    vlpd_pkg::result_t data_reg;

    // slot frees up when empty or when the held beat leaves this cycle
    assign free = !valid_reg || !stall;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (!stall)
        begin
            valid_next = 1'b0;
        end
    end

    // valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= load_data;
        end
    end

    assign valid = valid_reg;
    assign data = data_reg;

endmodule

### tb/sv/tb_varint_length_packet_deframer.sv
`timescale 1ns / 1ps

module tb_varint_length_packet_deframer;

    localparam int IDLE_LIMIT = 2000;
    localparam int SETTLE_CYCLES = 4;
    localparam int RANDOM_BYTES = 1500;
    localparam int NOISE_BYTES = 20;
    localparam logic [vlpd_pkg::LEN_W-1:0] LEN_MAX = '1;
    localparam logic [1:0] CODE_NONE = 2'd0;

    typedef enum logic { ROW_BYTE, ROW_REG } row_op_t;
    typedef enum logic [1:0] { CHK_MODEL, CHK_NONE, CHK_BEAT } row_check_t;

    // how the stream is closed; the protocol error latches until reset
    typedef enum int {
        END_TOO_LARGE_FIRST,
        END_TOO_LARGE_LATE,
        END_TOO_LONG,
        END_ZERO_LENGTH,
        END_COMPRESSED,
        END_EMPTY_COMPRESSED,
        END_MAX_ZERO,
        END_COUNT
    } ending_t;

    typedef struct packed {
        row_op_t           op;
        logic              reg_idx;
        logic [31:0]       value;
        row_check_t        check;
        vlpd_pkg::result_t beat;
    } row_t;

    logic clk;
    logic rst_n = 1'b0;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [vlpd_pkg::ADDR_W-1:0] paddr = '0;
    logic [vlpd_pkg::DATA_W-1:0] pwdata = '0;
    logic [vlpd_pkg::DATA_W-1:0] prdata;
    logic pready;
    logic in_valid = 1'b0;
    logic in_stall;
    logic [7:0] byte_in = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic result_kind;
    logic [7:0] payload_byte;
    logic first_of_packet;
    logic last_of_packet;
    logic [1:0] error_code;

    // predictor copy of registers and parser state
    logic cfg_compressed;
    logic [vlpd_pkg::LEN_W-1:0] cfg_max_len;
    vlpd_pkg::phase_t parse_phase;
    int unsigned pkt_len;
    int unsigned data_len;
    int unsigned groups_seen;
    int unsigned bytes_left;
    bit first_pending;
    bit stream_dead;

    vlpd_pkg::result_t expected_beats[$];
    row_t directed_rows[$];
    row_t ending_rows[$];
    ending_t ending;

    int fail_count = 0;
    int beats_checked = 0;
    int bytes_sent = 0;
    int packets_sent = 0;
    int reg_writes = 0;
    int idle_cycles = 0;
    int stall_run = 0;
    bit calm = 1'b0;

    varint_length_packet_deframer dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .byte_in         (byte_in),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .result_kind     (result_kind),
        .payload_byte    (payload_byte),
        .first_of_packet (first_of_packet),
        .last_of_packet  (last_of_packet),
        .error_code      (error_code)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // table row builders
    function automatic row_t hdr_byte(logic [7:0] b);
        row_t r;
        r = '0;
        r.op = ROW_BYTE;
        r.value = 32'(b);
        r.check = CHK_NONE;
        return r;
    endfunction

    function automatic row_t data_byte(logic [7:0] b);
        row_t r;
        r = hdr_byte(b);
        r.check = CHK_MODEL;
        return r;
    endfunction

    function automatic row_t data_beat(logic [7:0] b, logic first, logic last);
        row_t r;
        r = hdr_byte(b);
        r.check = CHK_BEAT;
        r.beat.kind = vlpd_pkg::KIND_PAYLOAD;
        r.beat.payload = b;
        r.beat.first = first;
        r.beat.last = last;
        r.beat.code = CODE_NONE;
        return r;
    endfunction

    function automatic row_t error_beat(logic [7:0] b, logic [1:0] code);
        row_t r;
        r = hdr_byte(b);
        r.check = CHK_BEAT;
        r.beat.kind = vlpd_pkg::KIND_ERROR;
        r.beat.code = code;
        return r;
    endfunction

    function automatic row_t reg_write(logic idx, logic [31:0] v);
        row_t r;
        r = '0;
        r.op = ROW_REG;
        r.reg_idx = idx;
        r.value = v;
        return r;
    endfunction

    // predictor
    task automatic flag_error(input logic [1:0] code, output bit produced,
                              output vlpd_pkg::result_t beat);
        stream_dead = 1'b1;
        produced = 1'b1;
        beat = '0;
        beat.kind = vlpd_pkg::KIND_ERROR;
        beat.code = code;
    endtask

    task automatic close_header(input int unsigned dl_groups, output bit produced,
                                output vlpd_pkg::result_t beat);
        produced = 1'b0;
        beat = '0;
        if (pkt_len == 0)
            flag_error(vlpd_pkg::ERR_ZERO_LENGTH, produced, beat);
        else if (cfg_compressed && data_len != 0)
            flag_error(vlpd_pkg::ERR_COMPRESSED, produced, beat);
        else if (pkt_len <= dl_groups)
            flag_error(vlpd_pkg::ERR_ZERO_LENGTH, produced, beat);
        else
        begin
            bytes_left = pkt_len - dl_groups;
            first_pending = 1'b1;
            parse_phase = vlpd_pkg::PH_DATA;
            groups_seen = 0;
        end
    endtask

    task automatic deframe_step(input logic [7:0] b, output bit produced,
                                output vlpd_pkg::result_t beat);
        int unsigned k;
        int unsigned prior;
        int unsigned val;
        bit more;
        produced = 1'b0;
        beat = '0;
        if (stream_dead)
            return;

        // payload pass-through
        if (parse_phase == vlpd_pkg::PH_DATA)
        begin
            produced = 1'b1;
            beat.kind = vlpd_pkg::KIND_PAYLOAD;
            beat.payload = b;
            beat.first = first_pending;
            beat.last = (bytes_left <= 1);
            first_pending = 1'b0;
            if (bytes_left <= 1)
            begin
                bytes_left = 0;
                parse_phase = vlpd_pkg::PH_PLEN;
                groups_seen = 0;
            end
            else
                bytes_left--;
            return;
        end

        // varint group accumulation, range check before continue check
        k = (groups_seen >= vlpd_pkg::MAX_VARINT_BYTES) ?
            vlpd_pkg::MAX_VARINT_BYTES - 1 : groups_seen;
        prior = (k == 0) ? 0 : ((parse_phase == vlpd_pkg::PH_DLEN) ? data_len : pkt_len);
        val = prior | (int'(b[6:0]) << (vlpd_pkg::GROUP_W * k));
        more = b[7];
        if (val > cfg_max_len)
            flag_error(vlpd_pkg::ERR_TOO_LARGE, produced, beat);
        else if (more && k + 1 >= vlpd_pkg::MAX_VARINT_BYTES)
            flag_error(vlpd_pkg::ERR_TOO_LONG, produced, beat);
        else if (parse_phase == vlpd_pkg::PH_DLEN)
        begin
            data_len = val;
            if (more)
                groups_seen = k + 1;
            else
                close_header(k + 1, produced, beat);
        end
        else
        begin
            pkt_len = val;
            if (more)
                groups_seen = k + 1;
            else
            begin
                groups_seen = 0;
                data_len = 0;
                if (cfg_compressed)
                    parse_phase = vlpd_pkg::PH_DLEN;
                else
                    close_header(0, produced, beat);
            end
        end
    endtask

    // failure bookkeeping
    function automatic void note_failure(string msg);
        fail_count++;
        if (fail_count <= 10)
            $display("[%0t] %s", $realtime, msg);
    endfunction

    function automatic void check_field(string name, int want, int got);
        if (want != got)
            note_failure($sformatf("%s mismatch on beat %0d: expected 0x%0h, got 0x%0h",
                                   name, beats_checked, want, got));
    endfunction

    // result beat checker and idle watch
    always @(posedge clk)
    begin
        vlpd_pkg::result_t want;
        if (out_valid && !out_stall)
        begin
            if (expected_beats.size() == 0)
                note_failure($sformatf(
                    "unexpected beat: kind %0d byte 0x%0h first %0d last %0d code %0d",
                    result_kind, payload_byte, first_of_packet, last_of_packet,
                    error_code));
            else
            begin
                want = expected_beats.pop_front();
                check_field("result_kind", want.kind, result_kind);
                check_field("payload_byte", want.payload, payload_byte);
                check_field("first_of_packet", want.first, first_of_packet);
                check_field("last_of_packet", want.last, last_of_packet);
                check_field("error_code", want.code, error_code);
                beats_checked++;
            end
        end
        if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
            (psel && penable && pwrite && pready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    // receiver backpressure: short and long stalls, some calm stretches
    always @(posedge clk)
    begin
        int r;
        if (stall_run > 0)
            stall_run <= stall_run - 1;
        else
        begin
            r = $urandom_range(0, 99);
            if (r < 50)
            begin
                out_stall <= 1'b0;
                stall_run <= $urandom_range(1, 12);
            end
            else if (r < 60)
            begin
                out_stall <= 1'b0;
                stall_run <= $urandom_range(50, 200);
            end
            else if (r < 92)
            begin
                out_stall <= 1'b1;
                stall_run <= $urandom_range(0, 2);
            end
            else
            begin
                out_stall <= 1'b1;
                stall_run <= $urandom_range(10, 30);
            end
        end
    end

    initial
    begin
        wait (idle_cycles >= IDLE_LIMIT);
        $display("watchdog: nothing moved for %0d cycles", IDLE_LIMIT);
        $display("Simulation FAILED");
        $finish;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 70)
            return 0;
        if (r < 95)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // one byte beat on the input channel, prediction at acceptance
    task automatic send_byte(input logic [7:0] b, input row_check_t check,
                             input vlpd_pkg::result_t typed);
        int gap;
        bit produced;
        vlpd_pkg::result_t beat;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        byte_in <= b;
        do @(posedge clk); while (in_stall);
        deframe_step(b, produced, beat);
        if (check == CHK_BEAT)
            expected_beats.push_back(typed);
        else if (check == CHK_MODEL && produced)
            expected_beats.push_back(beat);
        bytes_sent++;
    endtask

    // hold the input until every expected beat is out and the pipe is quiet
    task automatic pause_until_drained();
        in_valid <= 1'b0;
        while (expected_beats.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [31:0] value);
        pause_until_drained();
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (idx == vlpd_pkg::REG_COMPRESSED_MODE)
            cfg_compressed = value[0];
        else
            cfg_max_len = value[vlpd_pkg::LEN_W-1:0];
        reg_writes++;
    endtask

    task automatic run_row(input row_t row);
        if (row.op == ROW_REG)
            write_reg(row.reg_idx, row.value);
        else
            send_byte(row.value[7:0], row.check, row.beat);
    endtask

    // well-formed packet: minimal or zero-padded length varint, then
    // in compressed mode a zero data length of one to three groups
    task automatic send_packet(input int unsigned len);
        int unsigned min_groups;
        int unsigned groups;
        int unsigned dl_groups;
        logic [7:0] b;
        if (len < (cfg_compressed ? 2 : 1))
            len = cfg_compressed ? 2 : 1;
        if (len > cfg_max_len)
            len = cfg_max_len;
        min_groups = (len < 128) ? 1 : ((len < 16384) ? 2 : 3);
        groups = ($urandom_range(0, 4) == 0) ?
                 $urandom_range(min_groups, vlpd_pkg::MAX_VARINT_BYTES) : min_groups;
        for (int i = 0; i < groups; i++)
        begin
            b = {(i < groups - 1), 7'(len >> (vlpd_pkg::GROUP_W * i))};
            send_byte(b, CHK_MODEL, '0);
        end
        dl_groups = 0;
        if (cfg_compressed)
        begin
            dl_groups = $urandom_range(1, (len - 1 < 3) ? len - 1 : 3);
            for (int i = 0; i < dl_groups; i++)
                send_byte((i < dl_groups - 1) ? 8'h80 : 8'h00, CHK_MODEL, '0);
        end
        for (int i = 0; i < len - dl_groups; i++)
            send_byte(8'($urandom_range(0, 255)), CHK_MODEL, '0);
        packets_sent++;
    endtask

    task automatic randomize_config();
        int r;
        logic [vlpd_pkg::LEN_W-1:0] max_len;
        logic mode;
        r = $urandom_range(0, 99);
        if (r < 10)
            max_len = 1;
        else if (r < 25)
            max_len = LEN_MAX;
        else if (r < 40)
            max_len = vlpd_pkg::MAX_LEN_RESET;
        else
            max_len = vlpd_pkg::LEN_W'($urandom_range(4, 300));
        mode = (max_len == 1) ? 1'b0 : 1'($urandom_range(0, 1));
        write_reg(vlpd_pkg::REG_MAX_PACKET_LENGTH, 32'(max_len));
        write_reg(vlpd_pkg::REG_COMPRESSED_MODE, 32'(mode));
    endtask

    function automatic int unsigned pick_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(1, 8);
        if (r < 95)
            return $urandom_range(9, 64);
        return $urandom_range(65, 600);
    endfunction

    initial
    begin
        int start_bytes;

        // predictor state after reset
        cfg_compressed = 1'b0;
        cfg_max_len = vlpd_pkg::MAX_LEN_RESET;
        parse_phase = vlpd_pkg::PH_PLEN;
        pkt_len = 0;
        data_len = 0;
        groups_seen = 0;
        bytes_left = 0;
        first_pending = 1'b1;
        stream_dead = 1'b0;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed packets
        directed_rows = '{
            hdr_byte(8'h01), data_beat(8'h00, 1'b1, 1'b1),
            hdr_byte(8'h03), data_byte(8'hFF), data_byte(8'h80), data_byte(8'h7F),
            // length two padded out to three groups
            hdr_byte(8'h82), hdr_byte(8'h80), hdr_byte(8'h00),
            data_byte(8'hAA), data_byte(8'h55),
            // smallest maximum
            reg_write(vlpd_pkg::REG_MAX_PACKET_LENGTH, 32'd1),
            hdr_byte(8'h01), data_beat(8'h5A, 1'b1, 1'b1),
            // largest maximum, compressed framing with zero data length
            reg_write(vlpd_pkg::REG_MAX_PACKET_LENGTH, 32'(LEN_MAX)),
            reg_write(vlpd_pkg::REG_COMPRESSED_MODE, 32'd1),
            hdr_byte(8'h04), hdr_byte(8'h80), hdr_byte(8'h00),
            data_byte(8'h11), data_byte(8'h22),
            hdr_byte(8'h02), hdr_byte(8'h00), data_beat(8'h33, 1'b1, 1'b1)
        };
        foreach (directed_rows[i])
            run_row(directed_rows[i]);

        // random well-formed traffic under changing settings
        randomize_config();
        start_bytes = bytes_sent;
        while (bytes_sent - start_bytes < RANDOM_BYTES)
        begin
            if ($urandom_range(0, 11) == 0)
                randomize_config();
            else if ($urandom_range(0, 29) == 0)
                pause_until_drained();
            calm = ($urandom_range(0, 4) == 0);
            send_packet(pick_length());
        end
        calm = 1'b0;

        // close the stream with one protocol error, then check bytes are dropped
        ending = ending_t'($urandom_range(0, END_COUNT - 1));
        case (ending)
            END_TOO_LARGE_FIRST:
                ending_rows = '{reg_write(vlpd_pkg::REG_COMPRESSED_MODE, 32'd0),
                                reg_write(vlpd_pkg::REG_MAX_PACKET_LENGTH, 32'd100),
                                error_beat(8'hE5, vlpd_pkg::ERR_TOO_LARGE)};
            END_TOO_LARGE_LATE:
                ending_rows = '{reg_write(vlpd_pkg::REG_COMPRESSED_MODE, 32'd0),
                                reg_write(vlpd_pkg::REG_MAX_PACKET_LENGTH, 32'd16383),
                                hdr_byte(8'hFF), hdr_byte(8'hFF),
                                error_beat(8'h01, vlpd_pkg::ERR_TOO_LARGE)};
            END_TOO_LONG:
                ending_rows = '{reg_write(vlpd_pkg::REG_COMPRESSED_MODE, 32'd0),
                                reg_write(vlpd_pkg::REG_MAX_PACKET_LENGTH, 32'(LEN_MAX)),
                                hdr_byte(8'hFF), hdr_byte(8'hFF),
                                error_beat(8'hFF, vlpd_pkg::ERR_TOO_LONG)};
            END_ZERO_LENGTH:
                ending_rows = '{reg_write(vlpd_pkg::REG_COMPRESSED_MODE, 32'd0),
                                reg_write(vlpd_pkg::REG_MAX_PACKET_LENGTH,
                                          32'(vlpd_pkg::MAX_LEN_RESET)),
                                error_beat(8'h00, vlpd_pkg::ERR_ZERO_LENGTH)};
            END_COMPRESSED:
                ending_rows = '{reg_write(vlpd_pkg::REG_COMPRESSED_MODE, 32'd1),
                                reg_write(vlpd_pkg::REG_MAX_PACKET_LENGTH,
                                          32'(vlpd_pkg::MAX_LEN_RESET)),
                                hdr_byte(8'h05),
                                error_beat(8'h01, vlpd_pkg::ERR_COMPRESSED)};
            END_EMPTY_COMPRESSED:
                ending_rows = '{reg_write(vlpd_pkg::REG_COMPRESSED_MODE, 32'd1),
                                reg_write(vlpd_pkg::REG_MAX_PACKET_LENGTH,
                                          32'(vlpd_pkg::MAX_LEN_RESET)),
                                hdr_byte(8'h03), hdr_byte(8'h80), hdr_byte(8'h80),
                                error_beat(8'h00, vlpd_pkg::ERR_ZERO_LENGTH)};
            default:
                ending_rows = '{reg_write(vlpd_pkg::REG_COMPRESSED_MODE, 32'd0),
                                reg_write(vlpd_pkg::REG_MAX_PACKET_LENGTH, 32'd0),
                                error_beat(8'h01, vlpd_pkg::ERR_TOO_LARGE)};
        endcase
        foreach (ending_rows[i])
            run_row(ending_rows[i]);
        repeat (NOISE_BYTES)
            send_byte(8'($urandom_range(0, 255)), CHK_MODEL, '0);

        pause_until_drained();
        if (expected_beats.size() != 0)
            note_failure($sformatf("%0d result beats never arrived", expected_beats.size()));

        $display("covered %0d bytes, %0d random packets, %0d beats checked, %0d reg writes",
                 bytes_sent, packets_sent, beats_checked, reg_writes);
        $display("stream closed by %s, trailing bytes dropped; %0d mismatches",
                 ending.name(), fail_count);
        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

### sim.f
hw/rtl/vlpd_pkg.sv
hw/rtl/vlpd_parse.sv
hw/rtl/vlpd_out_reg.sv
hw/rtl/varint_length_packet_deframer.sv
tb/sv/tb_varint_length_packet_deframer.sv
